// File: sv/rle_block_decoder_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RLE_BLOCK_DECODER_UNIT_DEFINES_SVH
`define RLE_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RLEBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rle block decoder: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RLEBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rle block decoder: assertion failed");

`endif

// File: sv/rlebd_pkg.sv
package rlebd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 7;
    localparam int unsigned RemW   = 18;
    localparam int unsigned OutDataW = 16;

    typedef enum logic [2:0] {
        PH_HDR_LO = 3'd0,
        PH_HDR_HI = 3'd1,
        PH_CTRL   = 3'd2,
        PH_RUNVAL = 3'd3,
        PH_LIT    = 3'd4
    } t_phase;

    typedef struct packed {
        logic              done;
        logic [CountW-1:0] len;
        logic [ByteW-1:0]  value;
    } t_run;

endpackage

// File: sv/rle_block_decoder_unit.sv
// Run-length block decoder. Takes one compressed byte per beat on the slave side and
// gives at most one run (value, length 1..127, block-done flag) per byte on the master
// side. It sustains one byte per clock while the skid entry is free;
// a run appears on the master side the cycle after its byte is accepted, unless an
// earlier run is still waiting there. A two-entry output stage (result register plus
// skid register) lets the input keep flowing while a run waits; the input stalls only
// when both entries hold runs. Each block opens with a two-byte little-endian plane
// length (output length is four times that), followed by control bytes: bit 7 set gives
// a repeat count and a value byte, bit 7 clear gives a count of literal bytes. Runs are
// clipped to the bytes still owed to the block, and any count left over when the block
// completes is dropped.
module rle_block_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] run_value, [14:8] run_length, [15] zero
    output logic        o_m_tuser    // [0] block_done
);

    localparam int unsigned CW = rlebd_pkg::CountW;
    localparam int unsigned RW = rlebd_pkg::RemW;

    rlebd_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_hdr_lo, n_hdr_lo;
    logic [RW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_repeat, n_repeat;
    logic [CW-1:0]     r_lit, n_lit;

    logic              r_out_valid, r_skid_valid;
    rlebd_pkg::t_run   r_out, r_skid;

    logic              s_accept;
    logic              emit;
    rlebd_pkg::t_run   run;
    logic [CW-1:0]     clip_len;
    logic [RW-1:0]     rem_after;
    logic [CW-1:0]     lit_dec;

    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        if ({{(RW-CW){1'b0}}, r_repeat} > r_rem) begin
            clip_len = r_rem[CW-1:0];
        end else begin
            clip_len = r_repeat;
        end
        lit_dec = r_lit - CW'(1);
    end

    always_comb begin
        n_phase  = r_phase;
        n_hdr_lo = r_hdr_lo;
        n_rem    = r_rem;
        n_repeat = r_repeat;
        n_lit    = r_lit;
        emit     = 1'b0;
        run.value = i_s_tdata;
        run.len   = CW'(1);
        run.done  = 1'b0;
        rem_after = r_rem;
        unique case (r_phase)
            rlebd_pkg::PH_HDR_HI: begin
                n_rem   = {i_s_tdata, r_hdr_lo, 2'b00};
                n_phase = (n_rem == '0) ? rlebd_pkg::PH_HDR_LO : rlebd_pkg::PH_CTRL;
            end
            rlebd_pkg::PH_CTRL: begin
                if (i_s_tdata[7]) begin
                    n_repeat = i_s_tdata[CW-1:0];
                    n_phase  = rlebd_pkg::PH_RUNVAL;
                end else begin
                    n_lit   = i_s_tdata[CW-1:0];
                    n_phase = (i_s_tdata[CW-1:0] == '0) ? rlebd_pkg::PH_CTRL
                                                         : rlebd_pkg::PH_LIT;
                end
            end
            rlebd_pkg::PH_RUNVAL: begin
                n_repeat = '0;
                n_phase  = rlebd_pkg::PH_CTRL;
                if (clip_len == '0) begin
                    if (r_rem == '0) begin
                        n_phase = rlebd_pkg::PH_HDR_LO;
                    end
                end else begin
                    emit    = 1'b1;
                    run.len = clip_len;
                end
            end
            rlebd_pkg::PH_LIT: begin
                if (r_rem == '0) begin
                    n_phase = rlebd_pkg::PH_HDR_LO;
                    n_lit   = '0;
                end else begin
                    n_lit = lit_dec;
                    if (lit_dec == '0) begin
                        n_phase = rlebd_pkg::PH_CTRL;
                    end
                    emit    = 1'b1;
                    run.len = CW'(1);
                end
            end
            default: begin
                n_hdr_lo = i_s_tdata;
                n_phase  = rlebd_pkg::PH_HDR_HI;
            end
        endcase
        if (emit) begin
            rem_after = r_rem - {{(RW-CW){1'b0}}, run.len};
            n_rem     = rem_after;
            run.done  = (rem_after == '0);
            if (run.done) begin
                n_phase  = rlebd_pkg::PH_HDR_LO;
                n_repeat = '0;
                n_lit    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rlebd_pkg::PH_HDR_LO;
            r_hdr_lo <= '0;
            r_rem    <= '0;
            r_repeat <= '0;
            r_lit    <= '0;
        end else if (s_accept) begin
            r_phase  <= n_phase;
            r_hdr_lo <= n_hdr_lo;
            r_rem    <= n_rem;
            r_repeat <= n_repeat;
            r_lit    <= n_lit;
        end
    end

    // Result register with skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (s_accept && emit) begin
                if (r_out_valid && !i_m_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_m_tready) begin
                // advance the skid entry, or drain
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && emit) begin
            if (r_out_valid && !i_m_tready) begin
                r_skid <= run;
            end else begin
                r_out <= run;
            end
        end else if (i_m_tready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.len, r_out.value};
    assign o_m_tuser  = r_out.done;

endmodule

// File: sv/rlebd_checker.sv
`include "rle_block_decoder_unit_defines.svh"

module rlebd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic s_beat;
    logic m_wait;
    logic [16:0] m_beat;
    logic [rlebd_pkg::CountW-1:0] out_len;

    assign s_beat  = i_s_tvalid && o_s_tready;
    assign m_wait  = o_m_tvalid && !i_m_tready;
    assign m_beat  = {o_m_tuser, o_m_tdata};
    assign out_len = o_m_tdata[rlebd_pkg::CountW+7:8];

    // hold a stalled master beat
    `RLEBD_ASSERT_NXT(a_m_hold, i_clk, i_rst_n, m_wait, o_m_tvalid && $stable(m_beat))
    `RLEBD_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, o_m_tvalid, out_len != '0)
    // input stalls only behind a pending result
    `RLEBD_ASSERT_IMP(a_stall_has_out, i_clk, i_rst_n, !o_s_tready, o_m_tvalid)
    `RLEBD_ASSERT_IMP(a_out_from_beat, i_clk, i_rst_n, $rose(o_m_tvalid), $past(s_beat))

endmodule

bind rle_block_decoder_unit rlebd_checker u_rlebd_checker (.*);

// File: sim/tb_rle_block_decoder_unit.sv
module tb_rle_block_decoder_unit;

    class run_scoreboard;
        rlebd_pkg::t_phase                  phase;
        logic [rlebd_pkg::ByteW-1:0]        hdr_lo;
        logic [rlebd_pkg::RemW-1:0]         remaining;
        logic [rlebd_pkg::CountW-1:0]       rep_cnt;
        logic [rlebd_pkg::CountW-1:0]       lit_cnt;
        rlebd_pkg::t_run                    pending_runs[$];
        int                                 errors;

        function new();
            phase     = rlebd_pkg::PH_HDR_LO;
            hdr_lo    = '0;
            remaining = '0;
            rep_cnt   = '0;
            lit_cnt   = '0;
            errors    = 0;
        endfunction

        function void emit_run(logic [rlebd_pkg::ByteW-1:0] value,
                               logic [rlebd_pkg::RemW-1:0] len);
            rlebd_pkg::t_run r;
            remaining = remaining - len;
            r.value = value;
            r.len   = len[rlebd_pkg::CountW-1:0];
            r.done  = (remaining == '0);
            pending_runs.insert(pending_runs.size(), r);
            // block complete: drop any leftover count, next byte is a header
            if (r.done) begin
                phase   = rlebd_pkg::PH_HDR_LO;
                rep_cnt = '0;
                lit_cnt = '0;
            end
        endfunction

        // advance the decoder state by one accepted byte
        function void note_byte(logic [rlebd_pkg::ByteW-1:0] b);
            logic [rlebd_pkg::RemW-1:0] n;
            case (phase)
                rlebd_pkg::PH_HDR_HI: begin
                    remaining = {b, hdr_lo, 2'b00};
                    phase = (remaining == '0) ? rlebd_pkg::PH_HDR_LO : rlebd_pkg::PH_CTRL;
                end
                rlebd_pkg::PH_CTRL: begin
                    if (b[7]) begin
                        rep_cnt = b[rlebd_pkg::CountW-1:0];
                        phase   = rlebd_pkg::PH_RUNVAL;
                    end else begin
                        lit_cnt = b[rlebd_pkg::CountW-1:0];
                        phase   = (lit_cnt == '0) ? rlebd_pkg::PH_CTRL : rlebd_pkg::PH_LIT;
                    end
                end
                rlebd_pkg::PH_RUNVAL: begin
                    n = '0;
                    n[rlebd_pkg::CountW-1:0] = rep_cnt;
                    rep_cnt = '0;
                    phase   = rlebd_pkg::PH_CTRL;
                    if (n > remaining) n = remaining;
                    if (n == '0) begin
                        if (remaining == '0) phase = rlebd_pkg::PH_HDR_LO;
                    end else begin
                        emit_run(b, n);
                    end
                end
                rlebd_pkg::PH_LIT: begin
                    if (remaining == '0) begin
                        phase   = rlebd_pkg::PH_HDR_LO;
                        lit_cnt = '0;
                    end else begin
                        lit_cnt = lit_cnt - 1'b1;
                        if (lit_cnt == '0) phase = rlebd_pkg::PH_CTRL;
                        n = '0;
                        n[0] = 1'b1;
                        emit_run(b, n);
                    end
                end
                default: begin
                    hdr_lo = b;
                    phase  = rlebd_pkg::PH_HDR_HI;
                end
            endcase
        endfunction

        task report(string msg);
            $display("run mismatch: %s", msg);
            errors++;
        endtask

        task check_run(logic [rlebd_pkg::OutDataW-1:0] data, logic user);
            rlebd_pkg::t_run r;
            if (pending_runs.size() == 0) begin
                report($sformatf("unexpected run tdata=%h tuser=%b", data, user));
                return;
            end
            r = pending_runs.pop_front();
            if (data[7:0] !== r.value)
                report($sformatf("run_value %h, want %h", data[7:0], r.value));
            if (data[14:8] !== r.len)
                report($sformatf("run_length %0d, want %0d", data[14:8], r.len));
            if (user !== r.done)
                report($sformatf("block_done %b, want %b", user, r.done));
            if (data[15] !== 1'b0)
                report($sformatf("tdata pad bit %b, want 0", data[15]));
        endtask

        function int pending();
            return pending_runs.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    run_scoreboard sb;
    bit            no_idle = 1'b0;
    int            hold_len = 0;
    int            bytes_sent = 0;
    logic [7:0]    stream_q[$];

    logic [7:0] directed_bytes [0:23] = '{
        8'h00, 8'h00,
        8'h01, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00,
        8'h02, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h7E, 8'h85, 8'hAB,
        8'h01, 8'h00, 8'h7F, 8'h11, 8'h22, 8'h33, 8'h44
    };

    rle_block_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("rle_block_decoder_unit verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    endtask

    task automatic queue_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    // well-formed block: header, then runs and literal groups filling it
    task automatic gen_block(input int unsigned plane_words);
        int unsigned rem;
        int unsigned lim;
        int unsigned cnt;
        int unsigned n;
        int unsigned sel;
        logic [7:0]  v;
        rem = plane_words * 4;
        queue_byte(plane_words[7:0]);
        queue_byte(plane_words[15:8]);
        while (rem > 0) begin
            lim = (rem < 127) ? rem : 127;
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                cnt = (sel == 0) ? $urandom_range(0, 127) : $urandom_range(1, lim);
                queue_byte(8'h80 | cnt[7:0]);
                v = 8'($urandom);
                queue_byte(v);
                rem -= (cnt < rem) ? cnt : rem;
            end else begin
                cnt = (sel == 5) ? $urandom_range(0, 127)
                                 : $urandom_range(1, (lim < 16) ? lim : 16);
                queue_byte(cnt[7:0]);
                n = (cnt < rem) ? cnt : rem;
                repeat (n) begin
                    v = 8'($urandom);
                    queue_byte(v);
                end
                rem -= n;
            end
        end
    endtask

    // keep random headers small so the following block stays short
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (sb.phase == rlebd_pkg::PH_HDR_HI) v = 8'($urandom_range(0, 3));
        return v;
    endfunction

    function automatic logic [7:0] resync_byte();
        logic [7:0] v;
        v = 8'($urandom);
        case (sb.phase)
            rlebd_pkg::PH_HDR_HI: v = 8'h00;
            rlebd_pkg::PH_CTRL:   v = 8'hFF;
            default:              v = v;
        endcase
        return v;
    endfunction

    task automatic send_noise(input int n);
        repeat (n) send_byte(noise_byte());
    endtask

    // finish whatever block is open so the next byte is a header
    task automatic resync();
        while (sb.phase != rlebd_pkg::PH_HDR_LO) send_byte(resync_byte());
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_run(m_tdata, m_tuser);
        end
    end

    initial begin
        int          blk;
        int unsigned plane;
        logic [7:0]  v;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        wait_drain();

        blk = 0;
        while (bytes_sent < 610) begin
            blk++;
            // stall the output long enough to back up into the input
            if (blk == 2) hold_len = 400;
            if (blk == 5) wait_drain();
            no_idle = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 15) == 0) begin
                plane = $urandom_range(0, 1023);
            end else begin
                plane = $urandom_range(0, 8);
            end
            gen_block(plane);
            send_stream();
            if ($urandom_range(0, 7) == 0) begin
                send_noise($urandom_range(3, 12));
                resync();
            end
        end

        // largest header: full remainder width, left open at the end
        no_idle = 1'b1;
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h05);
        repeat (5) begin
            v = 8'($urandom);
            queue_byte(v);
        end
        send_stream();
        no_idle = 1'b0;

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("rle_block_decoder_unit verification clean");
        end else begin
            $display("rle_block_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

// File: rle_block_decoder_unit.f
+incdir+sv
sv/rlebd_pkg.sv
sv/rle_block_decoder_unit.sv
sv/rlebd_checker.sv
sim/tb_rle_block_decoder_unit.sv
